// ===== design/edd_pkg.sv =====
// Package for the error diffusion dither: shared widths, register indexes,
// reset values and the per-pixel control struct.
// No dependencies.
package edd_pkg;

  // Payload widths.
  localparam int unsigned SampleW  = 8;
  localparam int unsigned ErrW     = 7;
  localparam int unsigned CarryW   = 6;
  localparam int unsigned QbW      = 4;
  localparam int unsigned LineW    = 11;

  // Configuration port.
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 11;

  localparam logic [CfgIdxW-1:0] CFG_QUANT_BITS    = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_DITHER_ENABLE = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_LINE_WIDTH    = 2'd2;

  localparam logic [QbW-1:0]   QUANT_BITS_RST = 4'd1;
  localparam logic             DITHER_RST     = 1'b1;
  localparam logic [LineW-1:0] LINE_WIDTH_RST = 11'd128;

  // Position flags of one pixel, decided when its request is taken.
  typedef struct packed {
    logic last;       // last pixel of its row
    logic first_row;  // no error comes from the row above
    logic sof;        // first pixel of a frame, clears carries
  } edd_ctl_t;

endpackage

// ===== design/edd_line_mem.sv =====
// Line memory holding the error passed down to the next row.
// One write port, one read port with registered read data. Uses edd_pkg.
module edd_line_mem
  import edd_pkg::*;
#(
  parameter int unsigned Depth = 1024,
  parameter int unsigned AW    = 10
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AW-1:0]     waddr_i,
  input  logic [ErrW-1:0]   wdata_i,
  input  logic              re_i,
  input  logic [AW-1:0]     raddr_i,
  output logic [ErrW-1:0]   rdata_o
);

  logic [ErrW-1:0] mem [Depth];
  logic [ErrW-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port; data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/edd_scan.sv =====
// Raster position tracker: column counter, first-row flag and end of row.
// Advances once per taken request. Uses edd_pkg.
module edd_scan
  import edd_pkg::*;
#(
  parameter int unsigned MaxWidth = 1024,
  parameter int unsigned AW       = 10
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             take_i,
  input  logic             sof_i,
  input  logic [LineW-1:0] line_width_i,
  output logic [AW-1:0]    col_o,
  output edd_ctl_t         ctl_o
);

  localparam int unsigned WW = $clog2(MaxWidth + 1);
  localparam int unsigned LW = (WW > LineW) ? WW : LineW;
  localparam logic [LW-1:0] MaxW = LW'(MaxWidth);

  logic [AW-1:0] col_q, col_d;
  logic          first_row_q, first_row_d;
  logic [AW-1:0] col_cur;
  logic          first_cur;
  logic [LW-1:0] width_ext;
  logic [LW-1:0] width_eff;
  logic          last;

  // Clamp the row width to 1..MaxWidth.
  always_comb begin
    width_ext = LW'(line_width_i);
    if (width_ext == '0) begin
      width_eff = LW'(1);
    end else if (width_ext > MaxW) begin
      width_eff = MaxW;
    end else begin
      width_eff = width_ext;
    end
  end

  // A frame start restarts the scan before the pixel is placed.
  assign col_cur   = sof_i ? '0 : col_q;
  assign first_cur = sof_i | first_row_q;
  assign last      = LW'(col_cur) >= (width_eff - LW'(1));

  assign col_o = col_cur;
  assign ctl_o = '{last: last, first_row: first_cur, sof: sof_i};

  // Next position.
  always_comb begin
    col_d       = col_q;
    first_row_d = first_row_q;
    if (take_i) begin
      if (last) begin
        col_d       = '0;
        first_row_d = 1'b0;
      end else begin
        col_d       = col_cur + AW'(1);
        first_row_d = first_cur;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      first_row_q <= 1'b1;
    end else begin
      col_q       <= col_d;
      first_row_q <= first_row_d;
    end
  end

endmodule

// ===== design/edd_diffuse.sv =====
// Quantizer and error spreader: sums the diffused error, quantizes, splits the
// remainder 7/5/3/1 and drives the line memory write port. Uses edd_pkg.
module edd_diffuse
  import edd_pkg::*;
#(
  parameter int unsigned AW = 10
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               fire_i,
  input  logic [SampleW-1:0] sample_i,
  input  logic [AW-1:0]      col_i,
  input  edd_ctl_t           ctl_i,
  input  logic [ErrW-1:0]    below_i,
  input  logic [QbW-1:0]     quant_bits_i,
  input  logic               dither_enable_i,
  output logic [SampleW-1:0] level_o,
  output logic [SampleW-1:0] code_o,
  output logic               we_o,
  output logic [AW-1:0]      waddr_o,
  output logic [ErrW-1:0]    wdata_o,
  output logic [ErrW-1:0]    end_data_o
);

  logic [CarryW-1:0]  rc_q, rc_d;
  logic [ErrW-1:0]    ph_q, ph_d;
  logic [ErrW-1:0]    pn_q, pn_d;
  logic               pend_valid_q, pend_valid_d;
  logic [AW-1:0]      pend_addr_q;
  logic [ErrW-1:0]    pend_data_q;

  logic [CarryW-1:0]  rc_cur;
  logic [ErrW-1:0]    ph_cur, pn_cur;
  logic [QbW-1:0]     qb;
  logic [2:0]         shamt;
  logic [SampleW:0]   sum;
  logic [SampleW-1:0] sum_sat;
  logic [SampleW-1:0] mask;
  logic [SampleW-1:0] level;
  logic [ErrW-1:0]    err;
  logic [9:0]         err3, err5, err7;
  logic [7:0]         left_sum;
  logic [7:0]         here_sum;
  logic [ErrW-1:0]    ph_new;

  // Carries start from zero at a frame start.
  assign rc_cur = ctl_i.sof ? '0 : rc_q;
  assign ph_cur = ctl_i.sof ? '0 : ph_q;
  assign pn_cur = ctl_i.sof ? '0 : pn_q;

  // Kept bits clamped to 1..8.
  always_comb begin
    if (quant_bits_i == '0) begin
      qb = QbW'(1);
    end else if (quant_bits_i > QbW'(8)) begin
      qb = QbW'(8);
    end else begin
      qb = quant_bits_i;
    end
  end
  assign shamt = 3'(QbW'(8) - qb);

  // Add the incoming error and saturate.
  always_comb begin
    sum = {1'b0, sample_i};
    if (dither_enable_i) begin
      sum = sum + (SampleW+1)'(rc_cur);
      if (!ctl_i.first_row) begin
        sum = sum + (SampleW+1)'(below_i);
      end
    end
    sum_sat = sum[SampleW] ? '1 : sum[SampleW-1:0];
  end

  // Quantize; the dropped low bits are the error.
  assign mask  = 8'hFF << shamt;
  assign level = sum_sat & mask;
  assign err   = dither_enable_i ? ErrW'(sum_sat & ~mask) : '0;

  assign err3 = 10'(err) * 10'd3;
  assign err5 = 10'(err) * 10'd5;
  assign err7 = 10'(err) * 10'd7;

  assign left_sum = 8'(ph_cur) + 8'(err3[9:4]);
  assign here_sum = 8'(pn_cur) + 8'(err5[9:4]);
  assign ph_new   = here_sum[ErrW-1:0];

  assign level_o = level;
  assign code_o  = level >> shamt;

  // Memory write: the lower-left entry of this pixel, or the last entry of a
  // row in the cycle after the row's final pixel (that cycle never has a
  // write of its own since the next pixel sits in column zero).
  assign we_o    = pend_valid_q | (fire_i & (col_i != '0));
  assign waddr_o = pend_valid_q ? pend_addr_q : (col_i - AW'(1));
  assign wdata_o = pend_valid_q ? pend_data_q : left_sum[ErrW-1:0];

  // Held row end data, for forwarding to a pixel of the same column.
  assign end_data_o = pend_data_q;

  // Carry state update.
  always_comb begin
    rc_d         = rc_q;
    ph_d         = ph_q;
    pn_d         = pn_q;
    pend_valid_d = 1'b0;
    if (fire_i) begin
      if (ctl_i.last) begin
        rc_d         = '0;
        ph_d         = '0;
        pn_d         = '0;
        pend_valid_d = 1'b1;
      end else begin
        rc_d = err7[9:4];
        ph_d = ph_new;
        pn_d = ErrW'(err[ErrW-1:4]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rc_q         <= '0;
      ph_q         <= '0;
      pn_q         <= '0;
      pend_valid_q <= 1'b0;
    end else begin
      rc_q         <= rc_d;
      ph_q         <= ph_d;
      pn_q         <= pn_d;
      pend_valid_q <= pend_valid_d;
    end
  end

  // Held row end entry.
  always_ff @(posedge clk_i) begin
    if (fire_i && ctl_i.last) begin
      pend_addr_q <= col_i;
      pend_data_q <= ph_new;
    end
  end

endmodule

// ===== design/error_diffusion_dither.sv =====
// Top level of the error diffusion dither: configuration registers, pipeline
// registers, line memory forwarding and output register.
// Depends on edd_pkg, edd_line_mem, edd_scan and edd_diffuse.
//
//   channel  direction  handshake                fields
//   in       sink       in_valid_i / in_stall_o  sample_i, start_of_frame_i
//   out      source     out_valid_o / out_stall_i level_o, code_o, end_of_line_o
//   cfg      sink       cfg_we_i                 cfg_index_i, cfg_wdata_i
//
// One request per clock is taken sustained while the output is not stalled; a
// pixel's result passes the middle stage and then the output register after
// its request is taken (the line memory read data and the quantize and spread
// stage share the middle stage, whose carry loop closes within that stage).
// Reset clears position, carries and valid flags; the line memory is not
// cleared and is valid only where written since reset.
// An output stall holds the output register; a new request is still taken
// while the middle stage is free.
module error_diffusion_dither
  import edd_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [SampleW-1:0]  sample_i,
  input  logic                start_of_frame_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [SampleW-1:0]  level_o,
  output logic [SampleW-1:0]  code_o,
  output logic                end_of_line_o
);

  localparam int unsigned AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  // Configuration registers.
  logic [QbW-1:0]   quant_bits_q;
  logic             dither_enable_q;
  logic [LineW-1:0] line_width_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quant_bits_q    <= QUANT_BITS_RST;
      dither_enable_q <= DITHER_RST;
      line_width_q    <= LINE_WIDTH_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_QUANT_BITS:    quant_bits_q    <= cfg_wdata_i[QbW-1:0];
        CFG_DITHER_ENABLE: dither_enable_q <= cfg_wdata_i[0];
        CFG_LINE_WIDTH:    line_width_q    <= cfg_wdata_i[LineW-1:0];
        default: ;
      endcase
    end
  end

  // Handshake and stage movement.
  logic b_valid_q, b_valid_d;
  logic out_valid_q, out_valid_d;
  logic take;
  logic out_take;
  logic b_fire;

  assign out_take   = ~out_valid_q | ~out_stall_i;
  assign b_fire     = b_valid_q & out_take;
  assign in_stall_o = b_valid_q & ~out_take;
  assign take       = in_valid_i & ~in_stall_o;

  assign b_valid_d   = take | (b_valid_q & ~b_fire);
  assign out_valid_d = b_fire | (out_valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      b_valid_q   <= b_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Position of the incoming pixel.
  logic [AW-1:0] scan_col;
  edd_ctl_t      scan_ctl;

  edd_scan #(
    .MaxWidth (MAX_WIDTH),
    .AW       (AW)
  ) u_scan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .take_i       (take),
    .sof_i        (start_of_frame_i),
    .line_width_i (line_width_q),
    .col_o        (scan_col),
    .ctl_o        (scan_ctl)
  );

  // Middle stage payload.
  logic [SampleW-1:0] b_sample_q;
  logic [AW-1:0]      b_col_q;
  edd_ctl_t           b_ctl_q;

  always_ff @(posedge clk_i) begin
    if (take) begin
      b_sample_q <= sample_i;
      b_col_q    <= scan_col;
      b_ctl_q    <= scan_ctl;
    end
  end

  // Line memory.
  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  logic [ErrW-1:0] mem_wdata;
  logic [ErrW-1:0] mem_rdata;

  edd_line_mem #(
    .Depth (MAX_WIDTH),
    .AW    (AW)
  ) u_line_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (take),
    .raddr_i (scan_col),
    .rdata_o (mem_rdata)
  );

  // Forward writes that land on the entry after its read was issued.
  logic            fwd_hit_q, fwd_hit_d;
  logic [ErrW-1:0] fwd_data_q, fwd_data_d;
  logic [ErrW-1:0] end_data;
  logic            end_hit;
  logic [ErrW-1:0] below;

  always_comb begin
    fwd_hit_d  = fwd_hit_q;
    fwd_data_d = fwd_data_q;
    if (take) begin
      fwd_hit_d  = mem_we && (mem_waddr == scan_col);
      fwd_data_d = mem_wdata;
    end else if (b_valid_q && mem_we && (mem_waddr == b_col_q)) begin
      fwd_hit_d  = 1'b1;
      fwd_data_d = mem_wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_hit_q <= 1'b0;
    end else begin
      fwd_hit_q <= fwd_hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_data_q <= fwd_data_d;
  end

  // With one pixel per row, the row end entry is written in the very cycle
  // that the next pixel of that column uses it; only the held row end write
  // can hit the column of the middle stage.
  assign end_hit = b_valid_q && mem_we && (mem_waddr == b_col_q);
  assign below   = end_hit ? end_data : (fwd_hit_q ? fwd_data_q : mem_rdata);

  // Quantize and spread.
  logic [SampleW-1:0] level;
  logic [SampleW-1:0] code;

  edd_diffuse #(
    .AW (AW)
  ) u_diffuse (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .fire_i          (b_fire),
    .sample_i        (b_sample_q),
    .col_i           (b_col_q),
    .ctl_i           (b_ctl_q),
    .below_i         (below),
    .quant_bits_i    (quant_bits_q),
    .dither_enable_i (dither_enable_q),
    .level_o         (level),
    .code_o          (code),
    .we_o            (mem_we),
    .waddr_o         (mem_waddr),
    .wdata_o         (mem_wdata),
    .end_data_o      (end_data)
  );

  // Output register.
  logic [SampleW-1:0] level_q;
  logic [SampleW-1:0] code_q;
  logic               eol_q;

  always_ff @(posedge clk_i) begin
    if (b_fire) begin
      level_q <= level;
      code_q  <= code;
      eol_q   <= b_ctl_q.last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign level_o       = level_q;
  assign code_o        = code_q;
  assign end_of_line_o = eol_q;

  // A pixel leaving the middle stage always shows up at the output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_fire |=> out_valid_o)
    else $error("result left the middle stage but no output is valid");

  // A held middle stage keeps its pixel and column.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (b_valid_q && !b_fire && !take) |=> (b_valid_q && $stable(b_col_q)))
    else $error("held pixel in the middle stage changed");

  // A frame start always enters at column zero on the first row.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && start_of_frame_i) |=> ((b_col_q == '0) && b_ctl_q.first_row))
    else $error("frame start did not restart the scan");

  // With one kept bit, the quantized code never has bits above the kept width.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (quant_bits_q == QbW'(1))) |-> (code_o[7:1] == '0))
    else $error("code wider than one kept bit");

endmodule

// ===== sim/error_diffusion_dither_tb.sv =====
// Self-checking testbench for error_diffusion_dither: a scoreboard class predicts
// level, code and end of line for every pixel request and checks each result.
// Depends on edd_pkg and the error_diffusion_dither top level.
module error_diffusion_dither_tb;
  import edd_pkg::*;

  localparam int unsigned MAX_W = 1024;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam logic [CfgIdxW-1:0] CFG_UNUSED = 2'd3;

  // Expected result of one pixel.
  typedef struct {
    logic [SampleW-1:0] level;
    logic [SampleW-1:0] code;
    logic               eol;
  } pixel_result_t;

  // Dither predictor and the queue of results it has worked out.
  class DitherScoreboard;
    bit [ErrW-1:0]   line_err[MAX_W];
    bit              line_written[MAX_W];
    bit [CarryW-1:0] carry;
    bit [ErrW-1:0]   part_here;
    bit [ErrW-1:0]   part_next;
    bit [LineW-1:0]  col;
    bit              first_row;
    bit [QbW-1:0]    qbits;
    bit              dith;
    bit [LineW-1:0]  width;
    pixel_result_t   expected_q[$];
    int              errors;
    int              results;

    function void reset_state();
      foreach (line_written[i]) line_written[i] = 1'b0;
      carry = '0;
      part_here = '0;
      part_next = '0;
      col = '0;
      first_row = 1'b1;
      qbits = QUANT_BITS_RST;
      dith = DITHER_RST;
      width = LINE_WIDTH_RST;
      errors = 0;
      results = 0;
    endfunction

    function void apply_config(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        CFG_QUANT_BITS:    qbits = data[QbW-1:0];
        CFG_DITHER_ENABLE: dith = data[0];
        CFG_LINE_WIDTH:    width = data[LineW-1:0];
        default: ;
      endcase
    endfunction

    // True when the next pixel would read a line entry never written since reset.
    function bit needs_frame();
      return !first_row && (col >= MAX_W || !line_written[col]);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Advance the predictor by one accepted pixel request.
    function void note_pixel(logic [SampleW-1:0] s, logic sof);
      int unsigned   bits;
      int unsigned   w;
      int unsigned   sum;
      int unsigned   mask;
      int unsigned   lvl;
      int unsigned   err;
      bit            last;
      pixel_result_t res;
      bits = qbits;
      if (bits < 1) bits = 1;
      if (bits > 8) bits = 8;
      w = width;
      if (w < 1) w = 1;
      if (w > MAX_W) w = MAX_W;
      if (sof) begin
        col = '0;
        carry = '0;
        part_here = '0;
        part_next = '0;
        first_row = 1'b1;
      end
      last = (col >= w - 1);
      sum = s;
      if (dith) begin
        sum += carry;
        if (!first_row && col < MAX_W) sum += line_err[col];
      end
      if (sum > 255) sum = 255;
      mask = (32'hFF << (8 - bits)) & 32'hFF;
      lvl = sum & mask;
      err = dith ? (sum - lvl) : 0;
      // Lower-left neighbour is complete once this pixel adds its share.
      if (col > 0 && col - 1 < MAX_W) begin
        line_err[col-1] = ErrW'(part_here + ((err * 3) >> 4));
        line_written[col-1] = 1'b1;
      end
      part_here = ErrW'(part_next + ((err * 5) >> 4));
      if (last) begin
        if (col < MAX_W) begin
          line_err[col] = part_here;
          line_written[col] = 1'b1;
        end
        part_here = '0;
        part_next = '0;
        carry = '0;
        col = '0;
        first_row = 1'b0;
      end else begin
        part_next = ErrW'(err >> 4);
        carry = CarryW'((err * 7) >> 4);
        col = col + 1'b1;
      end
      res.level = lvl[7:0];
      res.code = SampleW'(lvl >> (8 - bits));
      res.eol = last;
      expected_q.push_back(res);
    endfunction

    // Compare one accepted result with the oldest expectation.
    function void check_result(logic [SampleW-1:0] level, logic [SampleW-1:0] code,
                               logic eol);
      pixel_result_t exp_res;
      results++;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result level %0d code %0d eol %0d",
                 $time, level, code, eol);
        errors++;
        return;
      end
      exp_res = expected_q.pop_front();
      if (level !== exp_res.level) begin
        $display("%0t: level expected %0d actual %0d", $time, exp_res.level, level);
        errors++;
      end
      if (code !== exp_res.code) begin
        $display("%0t: code expected %0d actual %0d", $time, exp_res.code, code);
        errors++;
      end
      if (eol !== exp_res.eol) begin
        $display("%0t: end_of_line expected %0d actual %0d", $time, exp_res.eol, eol);
        errors++;
      end
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_wdata = '0;
  logic                in_valid = 1'b0;
  logic                in_stall_o;
  logic [SampleW-1:0]  sample = '0;
  logic                sof = 1'b0;
  logic                out_valid_o;
  logic                out_stall = 1'b0;
  logic [SampleW-1:0]  level_o;
  logic [SampleW-1:0]  code_o;
  logic                end_of_line_o;

  DitherScoreboard sb = new();
  bit feeding = 1'b0;
  bit no_idle = 1'b0;
  int unsigned cycle_count = 0;

  error_diffusion_dither #(
    .MAX_WIDTH(MAX_W)
  ) u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_wdata_i     (cfg_wdata),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall_o),
    .sample_i        (sample),
    .start_of_frame_i(sof),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall),
    .level_o         (level_o),
    .code_o          (code_o),
    .end_of_line_o   (end_of_line_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("error_diffusion_dither_tb failed");
      $finish;
    end
  end

  // Idle length: mostly none, some short, a few long.
  function automatic int idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offer one pixel request and wait until it is taken; ends on the taking edge.
  task automatic send_pixel(input logic [SampleW-1:0] s, input logic frame);
    logic fs;
    fs = frame | sb.needs_frame();
    in_valid <= 1'b1;
    sample <= s;
    sof <= fs;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_pixel(s, fs);
  endtask

  // Pause the input with a random gap unless the phase runs without idling.
  task automatic input_gap();
    int g;
    g = no_idle ? 0 : idle_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  // Stop offering and let every outstanding result drain before a register write.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk_i);
    sb.apply_config(idx, data);
  endtask

  task automatic cfg_done();
    cfg_we <= 1'b0;
  endtask

  // Random phase of well-formed raster rows with occasional new frames.
  task automatic run_phase(input int n_items);
    feeding = 1'b1;
    for (int k = 0; k < n_items; k++) begin
      send_pixel(SampleW'($urandom_range(0, 255)), $urandom_range(0, 59) == 0);
      input_gap();
    end
    feeding = 1'b0;
  endtask

  // Output side: random stalls and one long hold-off while requests keep coming.
  initial begin : receive_proc
    int  stall_left;
    int  hold_left;
    bit  held;
    stall_left = 0;
    hold_left = 0;
    held = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall) sb.check_result(level_o, code_o, end_of_line_o);
      if (!held && feeding && sb.results >= 200) begin
        held = 1'b1;
        hold_left = 150;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (no_idle) begin
        out_stall <= 1'b0;
        stall_left = 0;
      end else if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        stall_left = idle_len();
        if (stall_left > 0) begin
          out_stall <= 1'b1;
          stall_left--;
        end else begin
          out_stall <= 1'b0;
        end
      end
    end
  end

  initial begin : stimulus_proc
    int                  phase;
    int                  random_items;
    int unsigned         r;
    logic [CfgDataW-1:0] w;
    sb.reset_state();
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: one-bit extremes on a short row with full dither.
    cfg_write(CFG_QUANT_BITS, 11'd1);
    cfg_write(CFG_DITHER_ENABLE, 11'd1);
    cfg_write(CFG_LINE_WIDTH, 11'd4);
    cfg_done();
    send_pixel(8'd255, 1'b1);
    send_pixel(8'd0, 1'b0);
    send_pixel(8'd255, 1'b0);
    send_pixel(8'd128, 1'b0);
    send_pixel(8'd127, 1'b0);
    send_pixel(8'd1, 1'b0);
    send_pixel(8'd254, 1'b0);
    send_pixel(8'd0, 1'b0);
    send_pixel(8'd200, 1'b0);
    send_pixel(8'd100, 1'b0);

    // Width shrunk mid row: the next pixel ends the row.
    wait_idle();
    cfg_write(CFG_LINE_WIDTH, 11'd1);
    cfg_done();
    send_pixel(8'd50, 1'b0);
    send_pixel(8'd60, 1'b0);
    send_pixel(8'd70, 1'b0);

    // Zero quant bits and zero width are clamped; dither off quantizes only.
    wait_idle();
    cfg_write(CFG_QUANT_BITS, 11'd0);
    cfg_write(CFG_LINE_WIDTH, 11'd0);
    cfg_write(CFG_DITHER_ENABLE, 11'd0);
    cfg_done();
    send_pixel(8'd255, 1'b0);
    send_pixel(8'd129, 1'b0);
    send_pixel(8'd0, 1'b0);

    // Full precision, new frame, and a write to the unused index.
    wait_idle();
    cfg_write(CFG_QUANT_BITS, 11'd8);
    cfg_write(CFG_DITHER_ENABLE, 11'd1);
    cfg_write(CFG_LINE_WIDTH, 11'd3);
    cfg_write(CFG_UNUSED, 11'h7FF);
    cfg_done();
    send_pixel(8'd17, 1'b1);
    send_pixel(8'd255, 1'b0);
    send_pixel(8'd0, 1'b0);
    send_pixel(8'd255, 1'b0);
    send_pixel(8'd3, 1'b0);
    send_pixel(8'd250, 1'b0);

    // Random phases; one of them uses the widest line.
    phase = 0;
    random_items = 0;
    while (random_items < 1100) begin
      wait_idle();
      if (phase == 2) begin
        cfg_write(CFG_LINE_WIDTH, 11'h7FF);
        cfg_write(CFG_DITHER_ENABLE, 11'd1);
        cfg_write(CFG_QUANT_BITS, CfgDataW'($urandom_range(1, 8)));
        cfg_done();
        no_idle = 1'b0;
        run_phase(MAX_W + 20);
        random_items += MAX_W + 20;
      end else begin
        if ($urandom_range(0, 99) < 60) begin
          w = CfgDataW'($urandom_range(0, 15));
          if ($urandom_range(0, 3) == 0) w[CfgDataW-1:QbW] = (CfgDataW-QbW)'($urandom);
          cfg_write(CFG_QUANT_BITS, w);
        end
        if ($urandom_range(0, 99) < 50) begin
          w = ($urandom_range(0, 99) < 80) ? 11'd1 : 11'd0;
          if ($urandom_range(0, 3) == 0) w[CfgDataW-1:1] = (CfgDataW-1)'($urandom);
          cfg_write(CFG_DITHER_ENABLE, w);
        end
        if ($urandom_range(0, 99) < 60) begin
          r = $urandom_range(0, 99);
          if (r < 70) w = CfgDataW'($urandom_range(1, 12));
          else if (r < 92) w = CfgDataW'($urandom_range(13, 70));
          else if (r < 96) w = 11'd0;
          else w = CfgDataW'($urandom_range(1, 2));
          cfg_write(CFG_LINE_WIDTH, w);
        end
        cfg_done();
        no_idle = ($urandom_range(0, 3) == 0);
        r = $urandom_range(20, 90);
        run_phase(r);
        random_items += r;
      end
      phase++;
    end

    // Drain and report.
    no_idle = 1'b0;
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("error_diffusion_dither_tb passed");
    end else begin
      $display("error_diffusion_dither_tb failed");
    end
    $finish;
  end

endmodule
